// ----- rtl/pbf_pkg.sv -----
// Package for the packet byte buffer: opcode codes and payload field widths.
// No dependencies; used by the channel interfaces, the top level and the testbench.
package pbf_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FILL_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_PEEK  = 2'd1,
    OP_RANGE = 2'd2,
    OP_PULL  = 2'd3
  } op_t;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [FILL_W-1:0] fill_t;

endpackage

// ----- rtl/pbf_if.sv -----
// Valid/ready channel interfaces for the packet byte buffer.
// Depends on pbf_pkg for field types.
interface pbf_in_if;
  import pbf_pkg::*;
  logic  valid;
  logic  ready;
  op_t   opcode;
  byte_t push_byte;
  byte_t position;
  byte_t length;

  modport source (output valid, opcode, push_byte, position, length, input ready);
  modport sink   (input valid, opcode, push_byte, position, length, output ready);
endinterface

interface pbf_out_if;
  import pbf_pkg::*;
  logic  valid;
  logic  ready;
  byte_t read_byte;
  logic  ok;
  fill_t fill_level;

  modport source (output valid, read_byte, ok, fill_level, input ready);
  modport sink   (input valid, read_byte, ok, fill_level, output ready);
endinterface

// ----- rtl/packet_byte_fifo_top.sv -----
// Top level of the packet byte buffer: operation sequencer around one byte store.
// Depends on pbf_pkg, pbf_in_if / pbf_out_if and pbf_store.
//
//   channel | dir | payload                              | handshake
//   in_ch   | in  | opcode, push_byte, position, length   | valid/ready
//   out_ch  | out | read_byte, ok, fill_level            | valid/ready
//
// After reset the store is zeroed one entry per cycle, with in_ch.ready low until every entry is cleared.
// Push, peek and range check: an accepted item goes to the response step, whose result is registered onto out_ch.
// Pull of n bytes from a fill of h: the h - n bytes behind them move to the front,
// one byte moved per cycle through the single store read port and write port.
// One item is worked at a time; a result waiting on out_ch stalls only the next finish.
module packet_byte_fifo_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  pbf_in_if.sink     in_ch,
  pbf_out_if.source  out_ch
);
  import pbf_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [8:0]    DEPTH_9 = 9'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SHIFT, S_RESP} state_t;

  state_t        state_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] clr_r;
  logic [CW-1:0] shift_rd_r;
  logic [CW-1:0] shift_end_r;
  logic [AW-1:0] shift_wr_r;
  logic          wr_pend_r;
  logic          use_mem_r;
  logic          res_ok_r;
  logic          out_valid_r;
  byte_t         out_byte_r;
  logic          out_ok_r;
  fill_t         out_fill_r;

  logic          in_fire;
  logic          pos_in;
  logic          range_ok;
  logic          pull_ok;
  logic          push_ok;
  logic          shift_more;
  logic          resp_load;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign pos_in   = {1'b0, in_ch.position} < DEPTH_9;
  assign range_ok = ({1'b0, in_ch.position} + {1'b0, in_ch.length}) <= 9'(cnt_r);
  assign pull_ok  = (in_ch.length != '0) && (9'(cnt_r) >= {1'b0, in_ch.length});
  assign push_ok  = cnt_r < DEPTH_C;
  assign shift_more = shift_rd_r < shift_end_r;
  assign resp_load  = (state_r == S_RESP) && (!out_valid_r || out_ch.ready);

  // store port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
      end
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.opcode)
            OP_PUSH: begin
              mem_we    = push_ok;
              mem_waddr = AW'(cnt_r);
              mem_wdata = in_ch.push_byte;
            end
            OP_PEEK: begin
              mem_re    = pos_in;
              mem_raddr = AW'(in_ch.position);
            end
            OP_RANGE: begin
              mem_re    = pos_in && range_ok;
              mem_raddr = AW'(in_ch.position);
            end
            OP_PULL: begin
              mem_re    = 1'b0;
            end
            default: mem_re = 1'b0;
          endcase
        end
      end
      S_SHIFT: begin
        // read address stays at least len entries ahead of the write; len >= 1 keeps them apart
        mem_re    = shift_more;
        mem_raddr = AW'(shift_rd_r);
        mem_we    = wr_pend_r;
        mem_waddr = shift_wr_r;
        mem_wdata = mem_rdata;
      end
      S_RESP: mem_re = 1'b0;
      default: mem_re = 1'b0;
    endcase
  end

  pbf_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      clr_r       <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == LAST_A) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_ch.opcode)
              OP_PUSH: begin
                res_ok_r  <= push_ok;
                use_mem_r <= 1'b0;
                state_r   <= S_RESP;
                if (push_ok) begin
                  cnt_r <= cnt_r + CW'(1);
                end
              end
              OP_PEEK: begin
                res_ok_r  <= 1'b1;
                use_mem_r <= pos_in;
                state_r   <= S_RESP;
              end
              OP_RANGE: begin
                res_ok_r  <= range_ok;
                use_mem_r <= pos_in && range_ok;
                state_r   <= S_RESP;
              end
              OP_PULL: begin
                res_ok_r  <= pull_ok;
                use_mem_r <= 1'b0;
                if (pull_ok) begin
                  cnt_r       <= cnt_r - CW'(in_ch.length);
                  shift_rd_r  <= CW'(in_ch.length);
                  shift_end_r <= cnt_r;
                  shift_wr_r  <= '0;
                  wr_pend_r   <= 1'b0;
                  state_r     <= S_SHIFT;
                end else begin
                  state_r     <= S_RESP;
                end
              end
              default: begin
                res_ok_r  <= 1'b0;
                use_mem_r <= 1'b0;
                state_r   <= S_RESP;
              end
            endcase
          end
        end
        S_SHIFT: begin
          wr_pend_r <= shift_more;
          if (shift_more) begin
            shift_rd_r <= shift_rd_r + CW'(1);
          end
          if (wr_pend_r) begin
            shift_wr_r <= shift_wr_r + AW'(1);
          end
          if (!shift_more && !wr_pend_r) begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (resp_load) begin
            out_byte_r  <= use_mem_r ? mem_rdata : '0;
            out_ok_r    <= res_ok_r;
            out_fill_r  <= FILL_W'(cnt_r);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_byte  = out_byte_r;
  assign out_ch.ok         = out_ok_r;
  assign out_ch.fill_level = out_fill_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("fill count above depth");

  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.opcode == OP_PUSH && push_ok) |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("accepted push did not grow the fill count");

  a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && wr_pend_r) |-> CW'(shift_wr_r) < shift_rd_r)
    else $error("shift write caught up with its read");

  a_resp_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result raised outside the response step");

endmodule

// ----- rtl/pbf_store.sv -----
// Byte storage of the packet buffer: one write port, one read port with
// registered read data. Standalone; no package needed.
module pbf_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- dv/tb_packet_byte_fifo_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for packet_byte_fifo_top: directed table, then packet-shaped random ops.
// Depends on pbf_pkg, pbf_in_if / pbf_out_if and the packet_byte_fifo_top RTL.
module tb_packet_byte_fifo_top;
  import pbf_pkg::*;

  localparam int DEPTH        = 64;
  localparam int RANDOM_ITEMS = 950;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    byte_t read_byte;
    logic  ok;
    fill_t fill_level;
  } result_t;

  typedef struct packed {
    logic    fixed;
    result_t res;
  } pinned_t;

  typedef struct {
    op_t     op;
    byte_t   pb;
    byte_t   pos;
    byte_t   len;
    logic    fixed;
    result_t res;
  } row_t;

  logic clk;
  logic rst_n;

  pbf_in_if  in_ch ();
  pbf_out_if out_ch ();

  packet_byte_fifo_top #(.DEPTH(DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the buffer, advanced on every accepted item
  byte_t   shadow_store [DEPTH];
  int      shadow_fill;
  result_t expected_results [$];
  pinned_t pinned_results [$];
  row_t    directed_rows [$];

  int items_sent;
  int items_accepted;
  int results_checked;
  int mismatch_count;
  int cycle_count;
  int op_count [4];
  int pushes_dropped;
  int ranges_valid;
  int pulls_applied;
  int peak_fill;
  bit long_hold_done;

  // sender side
  int gen_held;
  int burst_left;
  bit filled_once;

  result_t got;
  result_t want;
  pinned_t pin;
  result_t pred;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic result_t predict_buffer_op(op_t op, byte_t pb, byte_t pos, byte_t len);
    result_t r;
    int      k;
    r = '0;
    op_count[op]++;
    case (op)
      OP_PUSH: begin
        if (shadow_fill < DEPTH) begin
          shadow_store[shadow_fill] = pb;
          shadow_fill++;
          r.ok = 1'b1;
        end else begin
          pushes_dropped++;
        end
      end
      OP_PEEK: begin
        r.read_byte = (pos < DEPTH) ? shadow_store[pos] : '0;
        r.ok        = 1'b1;
      end
      OP_RANGE: begin
        // no wrap: 8-bit operands summed as int
        if (int'(pos) + int'(len) <= shadow_fill) begin
          r.read_byte = (pos < DEPTH) ? shadow_store[pos] : '0;
          r.ok        = 1'b1;
          ranges_valid++;
        end
      end
      default: begin
        if (len != 0 && shadow_fill >= int'(len)) begin
          for (k = int'(len); k < shadow_fill && k < DEPTH; k++)
            shadow_store[k - int'(len)] = shadow_store[k];
          shadow_fill -= int'(len);
          r.ok = 1'b1;
          pulls_applied++;
        end
      end
    endcase
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    r.fill_level = fill_t'(shadow_fill);
    return r;
  endfunction

  // result check first: a result never belongs to the item accepted at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.read_byte, out_ch.ok, out_ch.fill_level};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, got byte %0h ok %0b fill %0d",
                   $time, got.read_byte, got.ok, got.fill_level);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (got.read_byte !== want.read_byte) begin
            mismatch_count++;
            $display("%0t: read_byte mismatch, expected %0h, got %0h",
                     $time, want.read_byte, got.read_byte);
          end
          if (got.ok !== want.ok) begin
            mismatch_count++;
            $display("%0t: ok mismatch, expected %0b, got %0b", $time, want.ok, got.ok);
          end
          if (got.fill_level !== want.fill_level) begin
            mismatch_count++;
            $display("%0t: fill_level mismatch, expected %0d, got %0d",
                     $time, want.fill_level, got.fill_level);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pin  = (pinned_results.size() != 0) ? pinned_results.pop_front() : '0;
        pred = predict_buffer_op(in_ch.opcode, in_ch.push_byte, in_ch.position, in_ch.length);
        expected_results.push_back(pin.fixed ? pin.res : pred);
        items_accepted++;
      end
    end
  end

  // receiver: segments of always-ready, random stalls or a periodic pattern, plus one long hold
  initial begin : receiver
    int mode;
    int seg;
    int period;
    int low_len;
    int phase;
    out_ch.ready <= 1'b0;
    phase = 0;
    forever begin
      mode    = $urandom_range(0, 2);
      seg     = $urandom_range(10, 80);
      period  = $urandom_range(2, 7);
      low_len = $urandom_range(1, period - 1);
      repeat (seg) begin
        @(posedge clk);
        if (!long_hold_done && results_checked >= HOLD_AFTER) begin
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          long_hold_done = 1'b1;
        end
        phase++;
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ((phase % period) >= low_len);
        endcase
      end
    end
  end

  function automatic void add_row(op_t op, int pb, int pos, int len, bit fixed,
                                  int rd, bit ok, int fill);
    row_t r;
    r.op    = op;
    r.pb    = byte_t'(pb);
    r.pos   = byte_t'(pos);
    r.len   = byte_t'(len);
    r.fixed = fixed;
    r.res   = '{byte_t'(rd), ok, fill_t'(fill)};
    directed_rows.push_back(r);
  endfunction

  // drives one item and returns at the edge where it is taken; valid stays high for a burst
  task automatic send_item(op_t op, byte_t pb, byte_t pos, byte_t len, pinned_t p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    pinned_results.push_back(p);
    case (op)
      OP_PUSH:  if (gen_held < DEPTH) gen_held++;
      OP_PULL:  if (len != 0 && gen_held >= int'(len)) gen_held -= int'(len);
      default:  ;
    endcase
    items_sent++;
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.push_byte <= pb;
    in_ch.position  <= pos;
    in_ch.length    <= len;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random(op_t op, int pb, int pos, int len);
    send_item(op, byte_t'(pb), byte_t'(pos), byte_t'(len), '0);
  endtask

  // typical packet: a run of pushes, a few lookups, then a pull from the front
  task automatic run_packet();
    int n;
    int pos;
    n = $urandom_range(1, 24);
    repeat (n) send_random(OP_PUSH, $urandom_range(0, 255), 0, 0);
    repeat ($urandom_range(1, 4)) begin
      pos = $urandom_range(0, gen_held);
      if ($urandom_range(0, 4) == 0)
        send_random(OP_PEEK, 0, $urandom_range(0, DEPTH - 1), 0);
      else if ($urandom_range(0, 5) == 0)
        send_random(OP_RANGE, 0, pos, $urandom_range(0, 255));
      else
        send_random(OP_RANGE, 0, pos, $urandom_range(0, gen_held - pos));
    end
    case ($urandom_range(0, 9))
      0:       send_random(OP_PULL, 0, 0, 0);
      1:       send_random(OP_PULL, 0, 0, gen_held + $urandom_range(1, 10));
      default: if (gen_held > 0) send_random(OP_PULL, 0, 0, $urandom_range(1, gen_held));
    endcase
  endtask

  // drive the buffer to full, probe its end, then empty it partly or wholly
  task automatic run_fill();
    while (gen_held < DEPTH) send_random(OP_PUSH, $urandom_range(0, 255), 0, 0);
    repeat (2) send_random(OP_PUSH, $urandom_range(0, 255), 0, 0);
    send_random(OP_RANGE, 0, DEPTH, 0);
    send_random(OP_RANGE, 0, 0, DEPTH);
    send_random(OP_RANGE, 0, 0, DEPTH + 1);
    send_random(OP_RANGE, 0, DEPTH - 1, 1);
    send_random(OP_PEEK, 0, DEPTH - 1, 0);
    send_random(OP_PEEK, 0, DEPTH, 0);
    if ($urandom_range(0, 1) == 0) send_random(OP_PULL, 0, 0, DEPTH);
    else send_random(OP_PULL, 0, 0, $urandom_range(1, DEPTH));
    send_random(OP_PEEK, 0, $urandom_range(0, DEPTH - 1), 0);
  endtask

  initial begin : stimulus
    pinned_t p;
    int      kind;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_PUSH;
    in_ch.push_byte  <= '0;
    in_ch.position   <= '0;
    in_ch.length     <= '0;
    shadow_fill      = 0;
    gen_held         = 0;
    burst_left       = 0;
    foreach (shadow_store[i]) shadow_store[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    //      op        byte  pos  len  fixed rd    ok fill
    add_row(OP_PEEK,  0,    0,   0,   1,    0,    1, 0);
    add_row(OP_PEEK,  0,    255, 0,   1,    0,    1, 0);
    add_row(OP_RANGE, 0,    0,   0,   1,    0,    1, 0);   // empty range on empty buffer
    add_row(OP_RANGE, 0,    0,   1,   1,    0,    0, 0);
    add_row(OP_PULL,  0,    0,   0,   1,    0,    0, 0);   // zero-length pull ignored
    add_row(OP_PULL,  0,    0,   1,   1,    0,    0, 0);   // pull beyond fill ignored
    add_row(OP_PUSH,  8'hFF, 0,  0,   1,    0,    1, 1);
    add_row(OP_PUSH,  8'h00, 0,  0,   1,    0,    1, 2);
    add_row(OP_PUSH,  8'hA5, 0,  0,   1,    0,    1, 3);
    add_row(OP_PEEK,  0,    0,   0,   1,    8'hFF, 1, 3);
    add_row(OP_RANGE, 0,    1,   2,   1,    0,    1, 3);
    add_row(OP_RANGE, 0,    255, 255, 1,    0,    0, 3);   // sum needs the ninth bit
    add_row(OP_RANGE, 0,    3,   0,   1,    0,    1, 3);
    add_row(OP_PULL,  0,    0,   255, 1,    0,    0, 3);
    add_row(OP_PULL,  0,    0,   1,   1,    0,    1, 2);
    add_row(OP_PEEK,  0,    2,   0,   1,    8'hA5, 1, 2);  // stale tail byte
    add_row(OP_PEEK,  0,    63,  0,   1,    0,    1, 2);
    add_row(OP_PEEK,  0,    64,  0,   1,    0,    1, 2);
    add_row(OP_PUSH,  8'h5A, 0,  0,   0,    0,    0, 0);
    add_row(OP_PEEK,  0,    1,   0,   0,    0,    0, 0);
    add_row(OP_RANGE, 0,    1,   2,   0,    0,    0, 0);
    add_row(OP_PULL,  0,    0,   3,   0,    0,    0, 0);

    foreach (directed_rows[i]) begin
      p = '{directed_rows[i].fixed, directed_rows[i].res};
      send_item(directed_rows[i].op, directed_rows[i].pb, directed_rows[i].pos,
                directed_rows[i].len, p);
    end

    while (items_sent < directed_rows.size() + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (!filled_once || kind == 9) begin
        run_fill();
        filled_once = 1'b1;
      end else if (kind < 7) begin
        run_packet();
      end else begin
        repeat ($urandom_range(1, 8))
          send_random(op_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255));
      end
    end

    in_ch.valid <= 1'b0;
    while (items_accepted != items_sent || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
    end
    $display("Covered %0d items: %0d push (%0d dropped when full), %0d peek,",
             items_accepted, op_count[OP_PUSH], pushes_dropped, op_count[OP_PEEK],
             " %0d range (%0d valid), %0d pull (%0d applied)",
             op_count[OP_RANGE], ranges_valid, op_count[OP_PULL], pulls_applied);
    $display("%0d results checked, %0d mismatches, peak fill %0d, long receiver hold %s",
             results_checked, mismatch_count, peak_fill, long_hold_done ? "done" : "missed");
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pbf_pkg.sv
rtl/pbf_if.sv
rtl/pbf_store.sv
rtl/packet_byte_fifo_top.sv
dv/tb_packet_byte_fifo_top.sv
